/* rtl/core/dfs_topo_pkg.sv */
// shared constants for the depth-first topological ordering block
package dfs_topo_pkg;

   localparam int FIELD_W = 6;

   localparam logic [1:0] ACT_CLEAR = 2'd0;
   localparam logic [1:0] ACT_ADD   = 2'd1;
   localparam logic [1:0] ACT_RUN   = 2'd2;

   localparam logic STS_OK   = 1'b0;
   localparam logic STS_DROP = 1'b1;

endpackage

/* rtl/core/dfs_topo_ram.sv */
// generic single-write single-read ram with registered read data
module dfs_topo_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/core/dfs_topological_order.sv */
// depth-first topological ordering engine: graph store, walk sequencer, result register
//
//   channel  direction  fields
//   req      in         action, from_vertex, to_vertex, is_before, start_vertex
//   rsp      out        vertex, last, status
//
// clear and ignored or dropped edges: answered from idle; stored edge: tail read of the
// list ram, then the writes
// run: list ram read of the start vertex, then per edge scanned an edge ram read, per push
// a list ram read of the new vertex, per pop a stack ram read, last pop no stack read
// reset clears list valid bits, visited bits, edge count and all control state
// a full result register stalls the walk at the next emit; req waits until idle with the result register free
module dfs_topological_order
   import dfs_topo_pkg::*;
#(
   parameter int MAX_VERTICES = 64,
   parameter int MAX_EDGES    = 256
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [1:0]         req_action,
   input  logic [FIELD_W-1:0] req_from_vertex,
   input  logic [FIELD_W-1:0] req_to_vertex,
   input  logic               req_is_before,
   input  logic [FIELD_W-1:0] req_start_vertex,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [FIELD_W-1:0] rsp_vertex,
   output logic               rsp_last,
   output logic               rsp_status
);

   localparam int VW = $clog2(MAX_VERTICES);
   localparam int DW = VW + 1;
   localparam int EW = $clog2(MAX_EDGES);
   localparam int CW = $clog2(MAX_EDGES + 1);
   localparam int RW = FIELD_W + 1;
   localparam int SW = VW + EW + 1 + EW;

   typedef enum logic [2:0] {
      ST_IDLE, ST_ADD, ST_START, ST_SCAN, ST_EDGE, ST_POP, ST_PUSH
   } state_type;

   state_type         state_ff, state_in;
   logic [CW-1:0]     edge_count_ff, edge_count_in;
   logic [MAX_VERTICES-1:0] head_valid_ff, head_valid_in;
   logic [MAX_VERTICES-1:0] visited_ff, visited_in;
   logic [VW-1:0]     top_v_ff, top_v_in;
   logic [EW-1:0]     cursor_ff, cursor_in;
   logic              cvalid_ff, cvalid_in;
   logic [EW-1:0]     tail_ff, tail_in;
   logic [DW-1:0]     depth_ff, depth_in;
   logic [VW-1:0]     add_src_ff, add_src_in;
   logic [VW-1:0]     add_dst_ff, add_dst_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [FIELD_W-1:0] rsp_vertex_ff, rsp_vertex_in;
   logic              rsp_last_ff, rsp_last_in;
   logic              rsp_status_ff, rsp_status_in;

   logic              tgt_wr_en, tgt_rd_en;
   logic [EW-1:0]     tgt_wr_addr, tgt_rd_addr;
   logic [VW-1:0]     tgt_wr_data, tgt_rd_data;
   logic              link_wr_en, link_rd_en;
   logic [EW-1:0]     link_wr_addr, link_rd_addr;
   logic [EW-1:0]     link_wr_data, link_rd_data;
   logic              vert_wr_en, vert_rd_en;
   logic [VW-1:0]     vert_wr_addr, vert_rd_addr;
   logic [2*EW-1:0]   vert_wr_data, vert_rd_data;
   logic              stk_wr_en, stk_rd_en;
   logic [VW-1:0]     stk_wr_addr, stk_rd_addr;
   logic [SW-1:0]     stk_wr_data, stk_rd_data;

   logic              out_free;
   logic              accept;
   logic              from_oor, to_oor, start_oor, edges_full;
   logic [EW-1:0]     row_head, row_tail;
   logic [VW-1:0]     edge_tgt;
   logic              edge_more;
   logic [DW-1:0]     depth_less2;

   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign req_ready  = (state_ff == ST_IDLE) && out_free;
   assign accept     = req_valid && req_ready;
   assign from_oor   = {1'b0, req_from_vertex} >= RW'(MAX_VERTICES);
   assign to_oor     = {1'b0, req_to_vertex} >= RW'(MAX_VERTICES);
   assign start_oor  = {1'b0, req_start_vertex} >= RW'(MAX_VERTICES);
   assign edges_full = edge_count_ff == CW'(MAX_EDGES);
   assign row_head   = vert_rd_data[2*EW-1:EW];
   assign row_tail   = vert_rd_data[EW-1:0];
   assign edge_tgt   = tgt_rd_data;
   assign edge_more  = cursor_ff != tail_ff;
   assign depth_less2 = depth_ff - DW'(2);

   dfs_topo_ram #(.WIDTH(VW), .DEPTH(MAX_EDGES)) u_tgt_ram (
      .clock   (clock),
      .wr_en   (tgt_wr_en),
      .wr_addr (tgt_wr_addr),
      .wr_data (tgt_wr_data),
      .rd_en   (tgt_rd_en),
      .rd_addr (tgt_rd_addr),
      .rd_data (tgt_rd_data)
   );

   dfs_topo_ram #(.WIDTH(EW), .DEPTH(MAX_EDGES)) u_link_ram (
      .clock   (clock),
      .wr_en   (link_wr_en),
      .wr_addr (link_wr_addr),
      .wr_data (link_wr_data),
      .rd_en   (link_rd_en),
      .rd_addr (link_rd_addr),
      .rd_data (link_rd_data)
   );

   dfs_topo_ram #(.WIDTH(2*EW), .DEPTH(MAX_VERTICES)) u_vert_ram (
      .clock   (clock),
      .wr_en   (vert_wr_en),
      .wr_addr (vert_wr_addr),
      .wr_data (vert_wr_data),
      .rd_en   (vert_rd_en),
      .rd_addr (vert_rd_addr),
      .rd_data (vert_rd_data)
   );

   dfs_topo_ram #(.WIDTH(SW), .DEPTH(MAX_VERTICES)) u_stack_ram (
      .clock   (clock),
      .wr_en   (stk_wr_en),
      .wr_addr (stk_wr_addr),
      .wr_data (stk_wr_data),
      .rd_en   (stk_rd_en),
      .rd_addr (stk_rd_addr),
      .rd_data (stk_rd_data)
   );

   always_comb begin
      state_in      = state_ff;
      edge_count_in = edge_count_ff;
      head_valid_in = head_valid_ff;
      visited_in    = visited_ff;
      top_v_in      = top_v_ff;
      cursor_in     = cursor_ff;
      cvalid_in     = cvalid_ff;
      tail_in       = tail_ff;
      depth_in      = depth_ff;
      add_src_in    = add_src_ff;
      add_dst_in    = add_dst_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_vertex_in = rsp_vertex_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_status_in = rsp_status_ff;

      tgt_wr_en    = 1'b0;
      tgt_wr_addr  = edge_count_ff[EW-1:0];
      tgt_wr_data  = add_dst_ff;
      tgt_rd_en    = 1'b0;
      tgt_rd_addr  = cursor_ff;
      link_wr_en   = 1'b0;
      link_wr_addr = row_tail;
      link_wr_data = edge_count_ff[EW-1:0];
      link_rd_en   = 1'b0;
      link_rd_addr = cursor_ff;
      vert_wr_en   = 1'b0;
      vert_wr_addr = add_src_ff;
      vert_wr_data = {edge_count_ff[EW-1:0], edge_count_ff[EW-1:0]};
      vert_rd_en   = 1'b0;
      vert_rd_addr = req_from_vertex[VW-1:0];
      stk_wr_en    = 1'b0;
      stk_wr_addr  = VW'(depth_ff - DW'(1));
      stk_wr_data  = {top_v_ff, link_rd_data, edge_more, tail_ff};
      stk_rd_en    = 1'b0;
      stk_rd_addr  = depth_less2[VW-1:0];

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_action)
                  ACT_CLEAR: begin
                     head_valid_in = '0;
                     edge_count_in = '0;
                     rsp_valid_in  = 1'b1;
                     rsp_vertex_in = '0;
                     rsp_last_in   = 1'b1;
                     rsp_status_in = STS_OK;
                  end
                  ACT_ADD: begin
                     if (!req_is_before || from_oor || to_oor || edges_full) begin
                        rsp_valid_in  = 1'b1;
                        rsp_vertex_in = '0;
                        rsp_last_in   = 1'b1;
                        rsp_status_in = req_is_before ? STS_DROP : STS_OK;
                     end else begin
                        vert_rd_en   = 1'b1;
                        vert_rd_addr = req_from_vertex[VW-1:0];
                        add_src_in   = req_from_vertex[VW-1:0];
                        add_dst_in   = req_to_vertex[VW-1:0];
                        state_in     = ST_ADD;
                     end
                  end
                  ACT_RUN: begin
                     visited_in = '0;
                     if (start_oor) begin
                        rsp_valid_in  = 1'b1;
                        rsp_vertex_in = req_start_vertex;
                        rsp_last_in   = 1'b1;
                        rsp_status_in = STS_OK;
                     end else begin
                        visited_in[req_start_vertex[VW-1:0]] = 1'b1;
                        vert_rd_en   = 1'b1;
                        vert_rd_addr = req_start_vertex[VW-1:0];
                        top_v_in     = req_start_vertex[VW-1:0];
                        state_in     = ST_START;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_ADD: begin
            tgt_wr_en  = 1'b1;
            vert_wr_en = 1'b1;
            if (head_valid_ff[add_src_ff]) begin
               link_wr_en   = 1'b1;
               vert_wr_data = {row_head, edge_count_ff[EW-1:0]};
            end
            head_valid_in[add_src_ff] = 1'b1;
            edge_count_in = edge_count_ff + CW'(1);
            rsp_valid_in  = 1'b1;
            rsp_vertex_in = '0;
            rsp_last_in   = 1'b1;
            rsp_status_in = STS_OK;
            state_in      = ST_IDLE;
         end
         ST_START: begin
            cursor_in = row_head;
            cvalid_in = head_valid_ff[top_v_ff];
            tail_in   = row_tail;
            depth_in  = DW'(1);
            state_in  = ST_SCAN;
         end
         ST_SCAN: begin
            if (cvalid_ff) begin
               tgt_rd_en  = 1'b1;
               link_rd_en = 1'b1;
               state_in   = ST_EDGE;
            end else if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_vertex_in = FIELD_W'(top_v_ff);
               rsp_last_in   = depth_ff == DW'(1);
               rsp_status_in = STS_OK;
               depth_in      = depth_ff - DW'(1);
               if (depth_ff == DW'(1)) begin
                  state_in = ST_IDLE;
               end else begin
                  stk_rd_en = 1'b1;
                  state_in  = ST_POP;
               end
            end
         end
         ST_EDGE: begin
            if (!visited_ff[edge_tgt] && depth_ff < DW'(MAX_VERTICES)) begin
               visited_in[edge_tgt] = 1'b1;
               stk_wr_en    = 1'b1;
               top_v_in     = edge_tgt;
               vert_rd_en   = 1'b1;
               vert_rd_addr = edge_tgt;
               depth_in     = depth_ff + DW'(1);
               state_in     = ST_PUSH;
            end else begin
               cursor_in = link_rd_data;
               cvalid_in = edge_more;
               state_in  = ST_SCAN;
            end
         end
         ST_POP: begin
            {top_v_in, cursor_in, cvalid_in, tail_in} = stk_rd_data;
            state_in = ST_SCAN;
         end
         ST_PUSH: begin
            cursor_in = row_head;
            cvalid_in = head_valid_ff[top_v_ff];
            tail_in   = row_tail;
            state_in  = ST_SCAN;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         edge_count_ff <= '0;
         head_valid_ff <= '0;
         visited_ff    <= '0;
         cvalid_ff     <= 1'b0;
         depth_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         edge_count_ff <= edge_count_in;
         head_valid_ff <= head_valid_in;
         visited_ff    <= visited_in;
         cvalid_ff     <= cvalid_in;
         depth_ff      <= depth_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      top_v_ff      <= top_v_in;
      cursor_ff     <= cursor_in;
      tail_ff       <= tail_in;
      add_src_ff    <= add_src_in;
      add_dst_ff    <= add_dst_in;
      rsp_vertex_ff <= rsp_vertex_in;
      rsp_last_ff   <= rsp_last_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_vertex = rsp_vertex_ff;
   assign rsp_last   = rsp_last_ff;
   assign rsp_status = rsp_status_ff;

`ifndef SYNTHESIS
   a_depth_bound: assert property (@(posedge clock) disable iff (reset)
      depth_ff <= DW'(MAX_VERTICES))
      else $error("walk stack deeper than vertex count");

   a_edge_bound: assert property (@(posedge clock) disable iff (reset)
      edge_count_ff <= CW'(MAX_EDGES))
      else $error("edge count beyond edge store");

   a_walk_depth: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN || state_ff == ST_EDGE || state_ff == ST_PUSH)
      |-> depth_ff != '0)
      else $error("walk step with empty stack");

   a_top_visited: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> visited_ff[top_v_ff])
      else $error("top of stack not marked visited");

   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ADD) |-> !rsp_valid_ff)
      else $error("edge acknowledgement would overwrite a pending result");
`endif

endmodule

/* tb/sv/tb_dfs_topological_order.sv */
// self-checking testbench for the depth-first topological ordering block
`timescale 1ns / 1ps

module tb_dfs_topological_order;
   import dfs_topo_pkg::*;

   localparam int VERTEX_SLOTS   = 64;
   localparam int EDGE_SLOTS     = 256;
   localparam logic [1:0] ACT_NONE = 2'd3;
   localparam int WATCHDOG_LIMIT = 20000;
   localparam int SETTLE_CYCLES  = 64;

   typedef struct packed {
      logic [FIELD_W-1:0] vertex;
      logic               last;
      logic               status;
   } topo_result_type;

   class topo_scoreboard;
      bit [FIELD_W-1:0] edge_dst [EDGE_SLOTS];
      int               edge_link [EDGE_SLOTS];
      bit               edge_has_link [EDGE_SLOTS];
      int               first_edge [VERTEX_SLOTS];
      bit               has_edges [VERTEX_SLOTS];
      int               last_edge [VERTEX_SLOTS];
      int               n_edges;
      topo_result_type  pending [$];
      int               errors;
      int               n_walks;
      int               n_emitted;
      int               n_refused;

      function new();
         clear_graph();
         errors = 0;
         n_walks = 0;
         n_emitted = 0;
         n_refused = 0;
      endfunction

      function void clear_graph();
         foreach (has_edges[v]) has_edges[v] = 1'b0;
         n_edges = 0;
      endfunction

      function void expect_ack(logic status);
         topo_result_type r;
         r.vertex = '0;
         r.last   = 1'b1;
         r.status = status;
         pending.insert(pending.size(), r);
      endfunction

      function logic store_edge(logic [FIELD_W-1:0] src, logic [FIELD_W-1:0] dst);
         int e;
         if (n_edges >= EDGE_SLOTS) begin
            n_refused++;
            return STS_DROP;
         end
         e = n_edges;
         edge_dst[e] = dst;
         edge_has_link[e] = 1'b0;
         if (has_edges[src]) begin
            edge_link[last_edge[src]] = e;
            edge_has_link[last_edge[src]] = 1'b1;
         end else begin
            first_edge[src] = e;
            has_edges[src] = 1'b1;
         end
         last_edge[src] = e;
         n_edges++;
         return STS_OK;
      endfunction

      function void walk_from(logic [FIELD_W-1:0] root);
         bit               seen [VERTEX_SLOTS];
         bit [FIELD_W-1:0] stack_v [VERTEX_SLOTS];
         int               cursor [VERTEX_SLOTS];
         bit               cursor_ok [VERTEX_SLOTS];
         int               depth;
         int               top;
         int               e;
         bit               pushed;
         bit [FIELD_W-1:0] dst;
         topo_result_type  order [$];
         topo_result_type  r;
         foreach (seen[v]) seen[v] = 1'b0;
         seen[root] = 1'b1;
         stack_v[0] = root;
         cursor[0] = first_edge[root];
         cursor_ok[0] = has_edges[root];
         depth = 1;
         while (depth > 0) begin
            top = depth - 1;
            pushed = 1'b0;
            while (cursor_ok[top] && !pushed) begin
               e = cursor[top];
               dst = edge_dst[e];
               cursor_ok[top] = edge_has_link[e];
               cursor[top] = edge_link[e];
               if (!seen[dst] && depth < VERTEX_SLOTS) begin
                  seen[dst] = 1'b1;
                  stack_v[depth] = dst;
                  cursor[depth] = first_edge[dst];
                  cursor_ok[depth] = has_edges[dst];
                  depth++;
                  pushed = 1'b1;
               end
            end
            if (!pushed) begin
               r.vertex = stack_v[top];
               r.last   = 1'b0;
               r.status = STS_OK;
               order.insert(order.size(), r);
               depth--;
            end
         end
         foreach (order[i]) begin
            r = order[i];
            r.last = (i == order.size() - 1);
            pending.insert(pending.size(), r);
         end
         n_walks++;
      endfunction

      function void note_request(logic [1:0] act, logic [FIELD_W-1:0] src,
                                 logic [FIELD_W-1:0] dst, logic keep,
                                 logic [FIELD_W-1:0] start);
         case (act)
            ACT_CLEAR: begin
               clear_graph();
               expect_ack(STS_OK);
            end
            ACT_ADD: begin
               if (keep) expect_ack(store_edge(src, dst));
               else expect_ack(STS_OK);
            end
            ACT_RUN: walk_from(start);
            default: ;
         endcase
      endfunction

      function void check_result(logic [FIELD_W-1:0] vertex, logic last, logic status);
         topo_result_type want;
         if (pending.size() == 0) begin
            $display("%0t: unexpected result, vertex %0d last %0b status %0b",
                     $time, vertex, last, status);
            errors++;
            return;
         end
         want = pending[0];
         pending.delete(0);
         n_emitted++;
         if (vertex !== want.vertex) begin
            $display("%0t: vertex mismatch, expected %0d, actual %0d",
                     $time, want.vertex, vertex);
            errors++;
         end
         if (last !== want.last) begin
            $display("%0t: last mismatch, expected %0b, actual %0b", $time, want.last, last);
            errors++;
         end
         if (status !== want.status) begin
            $display("%0t: status mismatch, expected %0b, actual %0b",
                     $time, want.status, status);
            errors++;
         end
      endfunction
   endclass

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic [1:0]         req_action = ACT_CLEAR;
   logic [FIELD_W-1:0] req_from_vertex = '0;
   logic [FIELD_W-1:0] req_to_vertex = '0;
   logic               req_is_before = 1'b0;
   logic [FIELD_W-1:0] req_start_vertex = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic [FIELD_W-1:0] rsp_vertex;
   logic               rsp_last;
   logic               rsp_status;

   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int n_items = 0;
   int quiet_cycles = 0;

   topo_scoreboard sb = new();

   dfs_topological_order u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_action       (req_action),
      .req_from_vertex  (req_from_vertex),
      .req_to_vertex    (req_to_vertex),
      .req_is_before    (req_is_before),
      .req_start_vertex (req_start_vertex),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_vertex       (rsp_vertex),
      .rsp_last         (rsp_last),
      .rsp_status       (rsp_status)
   );

   always #4 clock = ~clock;

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) sb.check_result(rsp_vertex, rsp_last, rsp_status);
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet_cycles <= 0;
         else quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no transfer for %0d cycles", $time, quiet_cycles);
            $display("FAILURE");
            $finish;
         end
      end
   end

   function automatic logic [FIELD_W-1:0] any_vertex();
      return FIELD_W'($urandom_range(VERTEX_SLOTS - 1));
   endfunction

   function automatic logic [FIELD_W-1:0] vertex_in(int lo, int span);
      return FIELD_W'(lo + $urandom_range(span));
   endfunction

   task automatic send_item(input logic [1:0] act, input logic [FIELD_W-1:0] src,
                            input logic [FIELD_W-1:0] dst, input logic keep,
                            input logic [FIELD_W-1:0] start);
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_valid        <= 1'b1;
      req_action       <= act;
      req_from_vertex  <= src;
      req_to_vertex    <= dst;
      req_is_before    <= keep;
      req_start_vertex <= start;
      do @(posedge clock); while (!req_ready);
      sb.note_request(act, src, dst, keep, start);
      if (act != ACT_NONE) n_items++;
   endtask

   task automatic wait_for_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (sb.pending.size() != 0);
   endtask

   task automatic graph_session(input int n_adds, input int n_runs);
      int span;
      int lo;
      int roll;
      if ($urandom_range(99) < 80) span = $urandom_range(1, 11);
      else span = VERTEX_SLOTS - 1;
      lo = $urandom_range(0, VERTEX_SLOTS - 1 - span);
      if ($urandom_range(99) < 85)
         send_item(ACT_CLEAR, any_vertex(), any_vertex(), 1'($urandom_range(1)), any_vertex());
      repeat (n_adds) begin
         roll = $urandom_range(99);
         if (roll < 4)
            send_item(ACT_NONE, any_vertex(), any_vertex(), 1'($urandom_range(1)),
                      any_vertex());
         else
            send_item(ACT_ADD, vertex_in(lo, span), vertex_in(lo, span), roll >= 14,
                      any_vertex());
      end
      repeat (n_runs) begin
         if ($urandom_range(99) < 20) wait_for_results();
         send_item(ACT_RUN, any_vertex(), any_vertex(), 1'($urandom_range(1)),
                   ($urandom_range(99) < 85) ? vertex_in(lo, span) : any_vertex());
      end
   endtask

   initial begin
      send_idle_pct = 26;
      recv_idle_pct = 64;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // empty graph, ignored and unused requests, cycles, self loops, duplicates
      send_item(ACT_RUN,   6'd63, 6'd63, 1'b1, 6'd0);
      send_item(ACT_RUN,   6'd0,  6'd0,  1'b0, 6'd63);
      send_item(ACT_ADD,   6'd63, 6'd0,  1'b0, 6'd63);
      send_item(ACT_NONE,  6'd63, 6'd63, 1'b1, 6'd63);
      send_item(ACT_ADD,   6'd0,  6'd63, 1'b1, 6'd0);
      send_item(ACT_ADD,   6'd63, 6'd0,  1'b1, 6'd0);
      send_item(ACT_ADD,   6'd0,  6'd1,  1'b1, 6'd0);
      send_item(ACT_ADD,   6'd0,  6'd1,  1'b1, 6'd0);
      send_item(ACT_ADD,   6'd1,  6'd63, 1'b1, 6'd0);
      send_item(ACT_ADD,   6'd5,  6'd5,  1'b1, 6'd0);
      send_item(ACT_ADD,   6'd63, 6'd63, 1'b1, 6'd0);
      send_item(ACT_ADD,   6'd42, 6'd21, 1'b1, 6'd0);
      send_item(ACT_ADD,   6'd21, 6'd42, 1'b1, 6'd0);
      send_item(ACT_RUN,   6'd0,  6'd0,  1'b0, 6'd0);
      send_item(ACT_RUN,   6'd0,  6'd0,  1'b0, 6'd63);
      send_item(ACT_RUN,   6'd0,  6'd0,  1'b0, 6'd5);
      send_item(ACT_RUN,   6'd0,  6'd0,  1'b0, 6'd42);
      send_item(ACT_CLEAR, 6'd63, 6'd63, 1'b1, 6'd63);
      send_item(ACT_RUN,   6'd0,  6'd0,  1'b0, 6'd0);
      send_item(ACT_ADD,   6'd0,  6'd0,  1'b0, 6'd63);

      while (n_items < 28) graph_session($urandom_range(2, 14), $urandom_range(1, 3));
      wait_for_results();

      send_idle_pct = 64;
      recv_idle_pct = 26;
      while (n_items < 40) graph_session($urandom_range(2, 14), $urandom_range(1, 3));
      wait_for_results();

      // fill the edge store past its capacity, walking now and then
      send_idle_pct = 0;
      recv_idle_pct = 0;
      send_item(ACT_CLEAR, any_vertex(), any_vertex(), 1'b1, any_vertex());
      for (int i = 0; i < EDGE_SLOTS + 8; i++) begin
         send_item(ACT_ADD, any_vertex(), any_vertex(), 1'b1, any_vertex());
         if (i % 64 == 63)
            send_item(ACT_RUN, any_vertex(), any_vertex(), 1'($urandom_range(1)),
                      any_vertex());
      end
      repeat (4) send_item(ACT_ADD, any_vertex(), any_vertex(), 1'($urandom_range(1)),
                           any_vertex());
      repeat (3) send_item(ACT_RUN, any_vertex(), any_vertex(), 1'($urandom_range(1)),
                           any_vertex());
      graph_session($urandom_range(4, 14), 2);

      wait_for_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      $display("%0d requests under three idling mixes: %0d walks, %0d results checked",
               n_items, sb.n_walks, sb.n_emitted);
      $display("edge store filled to capacity with %0d edges refused", sb.n_refused);
      if (sb.errors == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

/* files.f */
rtl/core/dfs_topo_pkg.sv
rtl/core/dfs_topo_ram.sv
rtl/core/dfs_topological_order.sv
tb/sv/tb_dfs_topological_order.sv
